// File: sv/lom_pkg.sv
// lom_pkg: types, codes and defaults shared by the limit order matcher
// depends on nothing; imported by lom_front, lom_sorter, lom_back and limit_order_matcher
package lom_pkg;

   localparam int BOOK_DEPTH_DEFAULT = 16;
   localparam int CMD_DEPTH_DEFAULT = 2;
   localparam int RSP_DEPTH_DEFAULT = 4;

   localparam logic [1:0] ACT_LOAD_ASK = 2'd0;
   localparam logic [1:0] ACT_LOAD_BID = 2'd1;
   localparam logic [1:0] ACT_MATCH = 2'd2;

   localparam logic [1:0] ST_SALE = 2'd0;
   localparam logic [1:0] ST_LOADED = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;
   localparam logic [1:0] ST_NO_SALE = 2'd3;

   typedef struct packed {
      logic [1:0] action;
      logic [31:0] price;
      logic [31:0] amount;
      logic [15:0] time_id;
      logic [7:0] product_id;
      logic [7:0] user_id;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [31:0] sale_price;
      logic [31:0] sale_amount;
      logic [15:0] sale_time;
      logic [7:0] sale_product;
      logic bid_side;
      logic owned;
      logic last;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_LOAD_ASK,
      CMD_LOAD_BID,
      CMD_MATCH
   } cmd_kind_type;

   // tag packs time in 31..16, product in 15..8, owner in 7..0
   typedef struct packed {
      logic [31:0] price;
      logic [31:0] amount;
      logic [31:0] tag;
   } order_type;

   typedef struct packed {
      cmd_kind_type kind;
      order_type order;
   } cmd_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_GATHER,
      BACK_ASK_START,
      BACK_WALK,
      BACK_FINISH
   } back_state_type;

endpackage

// File: sv/lom_fifo.sv
// lom_fifo: small first-in first-out queue of any packed type
// depends on nothing outside itself
module lom_fifo #(
   parameter type data_type = logic,
   parameter int DEPTH = 2
) (
   input logic clock,
   input logic reset,
   input logic push,
   input data_type push_data,
   output logic full,
   input logic pop,
   output logic empty,
   output data_type pop_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   data_type mem [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic do_push, do_pop;

   assign full = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// File: sv/lom_front.sv
// lom_front: takes request items, sorts them into commands and queues them
// depends on lom_pkg and lom_fifo
module lom_front #(
   parameter int CMD_DEPTH = lom_pkg::CMD_DEPTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic push,
   output logic full,
   input lom_pkg::req_type req_item,
   input logic cmd_pop,
   output logic cmd_empty,
   output lom_pkg::cmd_type cmd
);
   import lom_pkg::*;

   cmd_type cmd_new;
   logic cmd_push;

   always_comb begin
      cmd_new.order.price = req_item.price;
      cmd_new.order.amount = req_item.amount;
      cmd_new.order.tag = {req_item.time_id, req_item.product_id, req_item.user_id};
      cmd_new.kind = CMD_MATCH;
      cmd_push = 1'b0;
      unique case (req_item.action)
         ACT_LOAD_ASK: begin
            cmd_new.kind = CMD_LOAD_ASK;
            cmd_push = push;
         end
         ACT_LOAD_BID: begin
            cmd_new.kind = CMD_LOAD_BID;
            cmd_push = push;
         end
         ACT_MATCH: begin
            cmd_new.kind = CMD_MATCH;
            cmd_push = push;
         end
         // unused action code: taken and dropped
         default: cmd_push = 1'b0;
      endcase
   end

   lom_fifo #(.data_type(cmd_type), .DEPTH(CMD_DEPTH)) u_cmd_q (
      .clock(clock),
      .reset(reset),
      .push(cmd_push),
      .push_data(cmd_new),
      .full(full),
      .pop(cmd_pop),
      .empty(cmd_empty),
      .pop_data(cmd)
   );
endmodule

// File: sv/lom_sorter.sv
// lom_sorter: row of order cells kept in price order by insertion
// depends on lom_pkg
module lom_sorter #(
   parameter int BOOK_DEPTH = lom_pkg::BOOK_DEPTH_DEFAULT,
   parameter bit ASCEND = 1'b1
) (
   input logic clock,
   input logic reset,
   input logic clear,
   input logic ins_valid,
   input lom_pkg::order_type ins_order,
   input logic [$clog2(BOOK_DEPTH)-1:0] rd_idx,
   output lom_pkg::order_type rd_order,
   input logic wr_en,
   input logic [$clog2(BOOK_DEPTH)-1:0] wr_idx,
   input logic [31:0] wr_price,
   input logic [31:0] wr_amount,
   output logic [$clog2(BOOK_DEPTH+1)-1:0] count
);
   import lom_pkg::*;

   localparam int CW = $clog2(BOOK_DEPTH + 1);

   order_type cell_ff [BOOK_DEPTH];
   order_type cell_in [BOOK_DEPTH];
   logic [BOOK_DEPTH-1:0] goes_here;
   logic [CW-1:0] count_ff;

   assign count = count_ff;
   assign rd_order = cell_ff[rd_idx];

   // goes_here[j]: new order belongs at or before cell j
   for (genvar j = 0; j < BOOK_DEPTH; j++) begin : g_cell
      logic occupied, earlier;
      assign occupied = CW'(j) < count_ff;
      always_comb begin
         if (ins_order.price == cell_ff[j].price) begin
            earlier = ins_order.amount > cell_ff[j].amount;
         end else if (ASCEND) begin
            earlier = ins_order.price < cell_ff[j].price;
         end else begin
            earlier = ins_order.price > cell_ff[j].price;
         end
         goes_here[j] = !occupied || earlier;
      end

      always_comb begin
         cell_in[j] = cell_ff[j];
         if (ins_valid && goes_here[j]) begin
            if (j > 0 && goes_here[(j > 0) ? j - 1 : 0]) begin
               cell_in[j] = cell_ff[(j > 0) ? j - 1 : 0];
            end else begin
               cell_in[j] = ins_order;
            end
         end else if (wr_en && wr_idx == ($clog2(BOOK_DEPTH))'(j)) begin
            cell_in[j].price = wr_price;
            cell_in[j].amount = wr_amount;
         end
      end

      always_ff @(posedge clock) begin
         cell_ff[j] <= cell_in[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         count_ff <= '0;
      end else if (ins_valid && count_ff != CW'(BOOK_DEPTH)) begin
         count_ff <= count_ff + 1'b1;
      end
   end
endmodule

// File: sv/lom_back.sv
// lom_back: order stores, match sequencer and result queue
// depends on lom_pkg, lom_sorter and lom_fifo
module lom_back #(
   parameter int BOOK_DEPTH = lom_pkg::BOOK_DEPTH_DEFAULT,
   parameter int RSP_DEPTH = lom_pkg::RSP_DEPTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic cmd_empty,
   input lom_pkg::cmd_type cmd,
   output logic cmd_pop,
   output logic empty,
   input logic pop,
   output lom_pkg::rsp_type rsp_item
);
   import lom_pkg::*;

   localparam int IW = $clog2(BOOK_DEPTH);
   localparam int CW = $clog2(BOOK_DEPTH + 1);

   order_type ask_mem [BOOK_DEPTH];
   order_type bid_mem [BOOK_DEPTH];
   order_type ask_rd_ff, bid_rd_ff;

   back_state_type state_ff, state_in;
   logic [CW-1:0] ask_cnt_ff, ask_cnt_in, bid_cnt_ff, bid_cnt_in;
   logic [CW-1:0] sweep_ff, sweep_in, i_ff, i_in, j_ff, j_in;
   logic [1:0] rdv_ff, rdv_in;
   logic [23:0] key_ff, key_in;
   logic [7:0] user_ff, user_in;
   logic [31:0] cur_ff, cur_in;
   rsp_type pend_ff, pend_in;
   logic pend_v_ff, pend_v_in;

   logic ask_we, bid_we, sort_clear, ask_ins, bid_ins;
   logic bid_wr_en;
   logic new_sale;
   logic [31:0] bid_wr_price, bid_wr_amount;
   logic [CW-1:0] ask_n, bid_n;
   order_type ask_w, bid_w;
   logic rsp_push, rsp_full;
   rsp_type rsp_data, sale;

   assign ask_ins = rdv_ff[1] && ask_rd_ff.tag[31:8] == key_ff;
   assign bid_ins = rdv_ff[0] && bid_rd_ff.tag[31:8] == key_ff;

   lom_sorter #(.BOOK_DEPTH(BOOK_DEPTH), .ASCEND(1'b1)) u_ask_sort (
      .clock(clock), .reset(reset), .clear(sort_clear),
      .ins_valid(ask_ins), .ins_order(ask_rd_ff),
      .rd_idx(i_ff[IW-1:0]), .rd_order(ask_w),
      .wr_en(1'b0), .wr_idx('0), .wr_price('0), .wr_amount('0),
      .count(ask_n)
   );

   lom_sorter #(.BOOK_DEPTH(BOOK_DEPTH), .ASCEND(1'b0)) u_bid_sort (
      .clock(clock), .reset(reset), .clear(sort_clear),
      .ins_valid(bid_ins), .ins_order(bid_rd_ff),
      .rd_idx(j_ff[IW-1:0]), .rd_order(bid_w),
      .wr_en(bid_wr_en), .wr_idx(j_ff[IW-1:0]),
      .wr_price(bid_wr_price), .wr_amount(bid_wr_amount),
      .count(bid_n)
   );

   lom_fifo #(.data_type(rsp_type), .DEPTH(RSP_DEPTH)) u_rsp_q (
      .clock(clock), .reset(reset),
      .push(rsp_push), .push_data(rsp_data), .full(rsp_full),
      .pop(pop), .empty(empty), .pop_data(rsp_item)
   );

   // one ask against one bid
   always_comb begin
      sale = '0;
      sale.status = ST_SALE;
      sale.sale_price = ask_w.price;
      sale.sale_time = ask_w.tag[31:16];
      sale.sale_product = ask_w.tag[15:8];
      sale.bid_side = bid_w.tag[7:0] == user_ff;
      sale.owned = sale.bid_side || ask_w.tag[7:0] == user_ff;
   end

   always_comb begin
      state_in = state_ff;
      ask_cnt_in = ask_cnt_ff;
      bid_cnt_in = bid_cnt_ff;
      sweep_in = sweep_ff;
      rdv_in = rdv_ff;
      i_in = i_ff;
      j_in = j_ff;
      key_in = key_ff;
      user_in = user_ff;
      cur_in = cur_ff;
      pend_in = pend_ff;
      pend_v_in = pend_v_ff;
      new_sale = 1'b0;
      cmd_pop = 1'b0;
      ask_we = 1'b0;
      bid_we = 1'b0;
      sort_clear = 1'b0;
      bid_wr_en = 1'b0;
      bid_wr_price = bid_w.price;
      bid_wr_amount = bid_w.amount;
      rsp_push = 1'b0;
      rsp_data = '0;
      rsp_data.last = 1'b1;
      unique case (state_ff)
         BACK_IDLE: begin
            if (!cmd_empty) begin
               unique case (cmd.kind)
                  CMD_LOAD_ASK: begin
                     if (!rsp_full) begin
                        cmd_pop = 1'b1;
                        rsp_push = 1'b1;
                        rsp_data.status = ST_FULL;
                        if (ask_cnt_ff < CW'(BOOK_DEPTH)) begin
                           ask_we = 1'b1;
                           ask_cnt_in = ask_cnt_ff + 1'b1;
                           rsp_data.status = ST_LOADED;
                        end
                     end
                  end
                  CMD_LOAD_BID: begin
                     if (!rsp_full) begin
                        cmd_pop = 1'b1;
                        rsp_push = 1'b1;
                        rsp_data.status = ST_FULL;
                        if (bid_cnt_ff < CW'(BOOK_DEPTH)) begin
                           bid_we = 1'b1;
                           bid_cnt_in = bid_cnt_ff + 1'b1;
                           rsp_data.status = ST_LOADED;
                        end
                     end
                  end
                  CMD_MATCH: begin
                     cmd_pop = 1'b1;
                     sort_clear = 1'b1;
                     key_in = cmd.order.tag[31:8];
                     user_in = cmd.order.tag[7:0];
                     sweep_in = '0;
                     rdv_in = '0;
                     pend_v_in = 1'b0;
                     state_in = BACK_GATHER;
                  end
                  default: cmd_pop = 1'b1;
               endcase
            end
         end
         BACK_GATHER: begin
            // read both stores in load order, one entry a cycle
            if (sweep_ff < ask_cnt_ff || sweep_ff < bid_cnt_ff) begin
               rdv_in = {sweep_ff < ask_cnt_ff, sweep_ff < bid_cnt_ff};
               sweep_in = sweep_ff + 1'b1;
            end else begin
               rdv_in = '0;
               if (rdv_ff == '0) begin
                  i_in = '0;
                  state_in = BACK_ASK_START;
               end
            end
         end
         BACK_ASK_START: begin
            if (i_ff >= ask_n) begin
               state_in = BACK_FINISH;
            end else begin
               cur_in = ask_w.amount;
               j_in = '0;
               state_in = BACK_WALK;
            end
         end
         BACK_WALK: begin
            if (j_ff >= bid_n) begin
               i_in = i_ff + 1'b1;
               state_in = BACK_ASK_START;
            end else if (!rsp_full) begin
               j_in = j_ff + 1'b1;
               if (bid_w.price >= ask_w.price) begin
                  if (bid_w.amount == cur_ff) begin
                     new_sale = 1'b1;
                     pend_in = sale;
                     pend_in.sale_amount = bid_w.amount;
                     pend_v_in = 1'b1;
                     bid_wr_en = 1'b1;
                     bid_wr_price = '0;
                     bid_wr_amount = '0;
                     cur_in = '0;
                     i_in = i_ff + 1'b1;
                     state_in = BACK_ASK_START;
                  end else if (bid_w.amount > cur_ff) begin
                     new_sale = 1'b1;
                     pend_in = sale;
                     pend_in.sale_amount = cur_ff;
                     pend_v_in = 1'b1;
                     bid_wr_en = 1'b1;
                     bid_wr_amount = bid_w.amount - cur_ff;
                     cur_in = '0;
                     i_in = i_ff + 1'b1;
                     state_in = BACK_ASK_START;
                  end else if (bid_w.amount != '0) begin
                     new_sale = 1'b1;
                     pend_in = sale;
                     pend_in.sale_amount = bid_w.amount;
                     pend_v_in = 1'b1;
                     bid_wr_en = 1'b1;
                     bid_wr_price = '0;
                     bid_wr_amount = '0;
                     cur_in = cur_ff - bid_w.amount;
                  end
               end
               // previous sale is now known not to be the final one
               if (new_sale && pend_v_ff) begin
                  rsp_push = 1'b1;
                  rsp_data = pend_ff;
                  rsp_data.last = 1'b0;
               end
            end
         end
         BACK_FINISH: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               if (pend_v_ff) begin
                  rsp_data = pend_ff;
               end else begin
                  rsp_data.status = ST_NO_SALE;
               end
               rsp_data.last = 1'b1;
               pend_v_in = 1'b0;
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BACK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ask_cnt_ff <= '0;
         bid_cnt_ff <= '0;
         rdv_ff <= '0;
         pend_v_ff <= 1'b0;
      end else begin
         ask_cnt_ff <= ask_cnt_in;
         bid_cnt_ff <= bid_cnt_in;
         rdv_ff <= rdv_in;
         pend_v_ff <= pend_v_in;
      end
   end

   always_ff @(posedge clock) begin
      sweep_ff <= sweep_in;
      i_ff <= i_in;
      j_ff <= j_in;
      key_ff <= key_in;
      user_ff <= user_in;
      cur_ff <= cur_in;
      pend_ff <= pend_in;
   end

   always_ff @(posedge clock) begin
      if (ask_we) begin
         ask_mem[ask_cnt_ff[IW-1:0]] <= cmd.order;
      end
      if (bid_we) begin
         bid_mem[bid_cnt_ff[IW-1:0]] <= cmd.order;
      end
      ask_rd_ff <= ask_mem[sweep_ff[IW-1:0]];
      bid_rd_ff <= bid_mem[sweep_ff[IW-1:0]];
   end
endmodule

// File: sv/limit_order_matcher.sv
// limit_order_matcher: a load item passes through the command queue, and its
// result through the result queue; loads flow at one per cycle while the result
// queue has room and no match is running. a match gathers both stores into the
// sorters, then walks the selected asks against the bids, one ask and one bid a
// cycle, stalling while the result queue is full.
// synchronous reset empties both stores and both queues; no clearing pass.
module limit_order_matcher #(
   parameter int BOOK_DEPTH = lom_pkg::BOOK_DEPTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   input logic push,
   output logic full,
   input lom_pkg::req_type req_item,
   output logic empty,
   input logic pop,
   output lom_pkg::rsp_type rsp_item
);
   import lom_pkg::*;

   cmd_type cmd;
   logic cmd_empty, cmd_pop;

   lom_front #(.CMD_DEPTH(CMD_DEPTH_DEFAULT)) u_front (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_item(req_item),
      .cmd_pop(cmd_pop), .cmd_empty(cmd_empty), .cmd(cmd)
   );

   lom_back #(.BOOK_DEPTH(BOOK_DEPTH), .RSP_DEPTH(RSP_DEPTH_DEFAULT)) u_back (
      .clock(clock), .reset(reset),
      .cmd_empty(cmd_empty), .cmd(cmd), .cmd_pop(cmd_pop),
      .empty(empty), .pop(pop), .rsp_item(rsp_item)
   );
endmodule
